// ----- design/itk_pkg.sv -----
// Shared types, constants and name-match helpers for the IRC message tokenizer.
// Used by itk_core, irc_message_tokenizer_top and the testbench; imports nothing.
`default_nettype none

package itk_pkg;

    // Default parameter values
    localparam int PAD_PARAMS_DEF = 6;
    localparam int MAX_PARAMS_DEF = 255;

    // Command name table
    localparam int NNAMES       = 11;
    localparam int MAX_RESULTS  = 3;
    localparam logic [3:0] CODE_NONE    = 4'd0;
    localparam logic [3:0] CODE_PRIVMSG = 4'd8;
    localparam logic [3:0] LEN_MAX      = 4'd15;

    // Names are left-justified in 8 bytes, first character in the top byte
    localparam logic [63:0] NAME_STR [NNAMES] = '{
        "INVITE  ", "JOIN    ", "KICK    ", "MODE    ", "NICK    ", "PART    ",
        "PASS    ", "PRIVMSG ", "QUIT    ", "TOPIC   ", "USER    "
    };
    localparam logic [3:0] NAME_LEN [NNAMES] = '{
        4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd4, 4'd5, 4'd4
    };

    // Special bytes
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_COMMAND = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // Position within the line
    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_WAITCMD,
        PH_CMD,
        PH_WAITPARAM,
        PH_PARAM,
        PH_REST,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] param_index;
        logic [7:0] data_byte;
        logic [3:0] command_code;
        logic       line_valid;
        logic [7:0] param_count;
        logic       last_of_run;
    } out_item_t;

    // All results caused by one byte
    typedef struct packed {
        logic [1:0]                       count;
        out_item_t [MAX_RESULTS-1:0]      items;
    } step_res_t;

    // Drop every candidate that cannot take this upper-cased byte at position len
    function automatic logic [NNAMES-1:0] match_cand(input logic [NNAMES-1:0] cand,
                                                      input logic [3:0] len,
                                                      input logic [7:0] up);
        logic [NNAMES-1:0] keep;
        logic [2:0]        pos;
        keep = cand;
        pos  = len[2:0];
        for (int i = 0; i < NNAMES; i++) begin
            if (len >= NAME_LEN[i] || NAME_STR[i][8*(7-int'(pos)) +: 8] != up)
                keep[i] = 1'b0;
        end
        return keep;
    endfunction

    // Lowest-numbered surviving name whose length matches the word
    function automatic logic [3:0] finish_cmd(input logic [NNAMES-1:0] cand,
                                              input logic [3:0] len);
        logic [3:0] code;
        code = CODE_NONE;
        for (int i = NNAMES - 1; i >= 0; i--) begin
            if (cand[i] && NAME_LEN[i] == len)
                code = 4'(i + 1);
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- design/irc_message_tokenizer_top.sv -----
// Top level of the IRC message tokenizer: input register, step core, result buffer.
// Depends on itk_pkg and itk_core.
`default_nettype none

// IRC message tokenizer. Bytes of one line come in on the char channel, one
// request per byte, with end_of_line set on the last byte. Each byte yields zero
// to three result items on the tok channel (parameter bytes, parameter ends, the
// command code, and a line summary at end of line); last_of_run marks the last
// item of a byte. A byte is held in an input register and is processed into a
// three-entry result buffer, which drains one item per unstalled cycle. A new
// byte is taken every unstalled cycle as long as bytes give at most one result
// each; a byte with more results holds the input until its last item drains.

module irc_message_tokenizer_top
    import itk_pkg::*;
#(
    parameter int PAD_PARAMS = PAD_PARAMS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      char_valid,
    output logic           char_stall,
    input  wire in_item_t  char_item,
    output logic           tok_valid,
    input  wire logic      tok_stall,
    output out_item_t      tok_item
);

    logic                         in_vld_reg;
    in_item_t                     in_item_reg;
    out_item_t [MAX_RESULTS-1:0]  slot_reg;
    logic [1:0]                   cnt_reg;
    step_res_t                    step_res;
    logic                         take;
    logic                         process;

    // Handshake decisions
    assign take       = (cnt_reg != 2'd0) && !tok_stall;
    assign process    = in_vld_reg && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && take));
    assign char_stall = in_vld_reg && !process;
    assign tok_valid  = (cnt_reg != 2'd0);
    assign tok_item   = slot_reg[0];

    itk_core #(
        .PAD_PARAMS (PAD_PARAMS),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process),
        .item  (in_item_reg),
        .res   (step_res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (char_valid && !char_stall) begin
            in_vld_reg <= 1'b1;
        end else if (process) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            in_item_reg <= char_item;
    end

    // Result buffer: load a whole step, or shift out one item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else if (process) begin
            cnt_reg <= step_res.count;
        end else if (take) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process) begin
            slot_reg <= step_res.items;
        end else if (take) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                slot_reg[i] <= slot_reg[i+1];
        end
    end

endmodule

`default_nettype wire

// ----- design/itk_core.sv -----
// Tokenizer line state and the per-byte step logic producing up to three results.
// Depends on itk_pkg.
`default_nettype none

module itk_core
    import itk_pkg::*;
#(
    parameter int PAD_PARAMS = PAD_PARAMS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire in_item_t  item,
    output step_res_t      res
);

    localparam logic [7:0] PAD_C = 8'(PAD_PARAMS);
    localparam logic [7:0] MAX_C = 8'(MAX_PARAMS);

    phase_t            phase_reg, phase_next;
    logic [NNAMES-1:0] cand_reg, cand_next, cand_m;
    logic [3:0]        len_reg, len_next, len_m;
    logic [3:0]        found_reg, found_next;
    logic [7:0]        cnt_reg, cnt_next;

    logic [7:0] b;
    logic [7:0] up;
    logic       ws;

    // Byte classification and the name match for this byte
    always_comb
    begin
        b      = item.char_byte;
        ws     = (b >= CHAR_TAB && b <= CHAR_CR) || b == CHAR_SPACE;
        up     = (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) ? b - CASE_OFFSET : b;
        cand_m = match_cand(cand_reg, len_reg, up);
        len_m  = (len_reg == LEN_MAX) ? LEN_MAX : len_reg + 4'd1;
    end

    // Step: next line state and the results for this byte
    always_comb
    begin
        logic [1:0] n;
        logic       line_ok;
        logic [7:0] sum_cnt;
        phase_next = phase_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        found_next = found_reg;
        cnt_next   = cnt_reg;
        res        = '0;
        n          = 2'd0;
        line_ok    = 1'b0;
        sum_cnt    = 8'd0;

        unique case (phase_reg)
            PH_START:
            begin
                if (!ws) begin
                    if (b == CHAR_COLON) begin
                        phase_next = PH_PREFIX;
                    end else begin
                        phase_next = PH_CMD;
                        cand_next  = cand_m;
                        len_next   = len_m;
                    end
                end
            end
            PH_PREFIX:
            begin
                if (ws)
                    phase_next = PH_WAITCMD;
            end
            PH_WAITCMD:
            begin
                if (!ws) begin
                    phase_next = PH_CMD;
                    cand_next  = cand_m;
                    len_next   = len_m;
                end
            end
            PH_CMD:
            begin
                if (ws) begin
                    found_next = finish_cmd(cand_reg, len_reg);
                    res.items[n].kind         = KIND_COMMAND;
                    res.items[n].command_code = found_next;
                    n          = n + 2'd1;
                    phase_next = PH_WAITPARAM;
                end else begin
                    cand_next = cand_m;
                    len_next  = len_m;
                end
            end
            PH_WAITPARAM:
            begin
                if (!ws) begin
                    if (b == CHAR_COLON) begin
                        phase_next = PH_REST;
                    end else begin
                        phase_next = (found_reg == CODE_PRIVMSG && cnt_reg == 8'd1)
                                     ? PH_REST : PH_PARAM;
                        res.items[n].kind        = KIND_BYTE;
                        res.items[n].param_index = cnt_reg;
                        res.items[n].data_byte   = b;
                        n = n + 2'd1;
                    end
                end
            end
            PH_PARAM:
            begin
                if (ws) begin
                    res.items[n].kind        = KIND_END;
                    res.items[n].param_index = cnt_reg;
                    n          = n + 2'd1;
                    cnt_next   = (cnt_reg < MAX_C) ? cnt_reg + 8'd1 : cnt_reg;
                    phase_next = PH_WAITPARAM;
                end else begin
                    res.items[n].kind        = KIND_BYTE;
                    res.items[n].param_index = cnt_reg;
                    res.items[n].data_byte   = b;
                    n = n + 2'd1;
                end
            end
            PH_REST:
            begin
                if (b == CHAR_NEWLINE) begin
                    res.items[n].kind        = KIND_END;
                    res.items[n].param_index = cnt_reg;
                    n          = n + 2'd1;
                    cnt_next   = (cnt_reg < MAX_C) ? cnt_reg + 8'd1 : cnt_reg;
                    phase_next = PH_DONE;
                end else begin
                    res.items[n].kind        = KIND_BYTE;
                    res.items[n].param_index = cnt_reg;
                    res.items[n].data_byte   = b;
                    n = n + 2'd1;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // End of line: close any open word, then the summary
        if (item.end_of_line) begin
            if (phase_next == PH_CMD) begin
                found_next = finish_cmd(cand_next, len_next);
                res.items[n].kind         = KIND_COMMAND;
                res.items[n].command_code = found_next;
                n          = n + 2'd1;
                phase_next = PH_WAITPARAM;
            end else if (phase_next == PH_PARAM || phase_next == PH_REST) begin
                res.items[n].kind        = KIND_END;
                res.items[n].param_index = cnt_next;
                n          = n + 2'd1;
                cnt_next   = (cnt_next < MAX_C) ? cnt_next + 8'd1 : cnt_next;
                phase_next = PH_DONE;
            end
            line_ok = (phase_next == PH_WAITPARAM) || (phase_next == PH_PARAM) ||
                      (phase_next == PH_REST) || (phase_next == PH_DONE);
            if (line_ok) begin
                sum_cnt = (cnt_next < PAD_C) ? PAD_C : cnt_next;
                if (sum_cnt > MAX_C)
                    sum_cnt = MAX_C;
                res.items[n].command_code = found_next;
            end
            res.items[n].kind        = KIND_SUMMARY;
            res.items[n].line_valid  = line_ok;
            res.items[n].param_count = sum_cnt;
            n = n + 2'd1;

            // fresh line
            phase_next = PH_START;
            cand_next  = '1;
            len_next   = 4'd0;
            found_next = CODE_NONE;
            cnt_next   = 8'd0;
        end

        if (n != 2'd0)
            res.items[n - 2'd1].last_of_run = 1'b1;
        res.count = n;
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_START;
            cand_reg  <= '1;
            len_reg   <= 4'd0;
            found_reg <= CODE_NONE;
            cnt_reg   <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            cand_reg  <= cand_next;
            len_reg   <= len_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/irc_message_tokenizer_checker.sv -----
// Scoreboard for the IRC message tokenizer: watches both request channels,
// predicts the token stream per accepted byte and compares in order.
// Depends on itk_pkg for the channel types, phases, kinds and byte constants.
`timescale 1ns / 100ps

module irc_message_tokenizer_checker
    import itk_pkg::*;
#(
    parameter int PAD_PARAMS = PAD_PARAMS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    input  logic      char_stall,
    input  in_item_t  char_item,
    input  logic      tok_valid,
    input  logic      tok_stall,
    input  out_item_t tok_item,
    output int        fail_count,
    output int        tokens_pending,
    output int        tokens_checked
);

    // Command names, 7 characters left-justified, first character on top
    localparam logic [55:0] CMD_NAME [NNAMES] = '{
        "INVITE ", "JOIN   ", "KICK   ", "MODE   ", "NICK   ", "PART   ",
        "PASS   ", "PRIVMSG", "QUIT   ", "TOPIC  ", "USER   "
    };
    localparam int CMD_LEN [NNAMES] = '{6, 4, 4, 4, 4, 4, 4, 7, 4, 5, 4};

    // Line tracking state of the model
    phase_t            ln_phase;
    logic [NNAMES-1:0] cand_mask;
    logic [3:0]        word_len;
    logic [3:0]        cmd_code;
    logic [7:0]        param_num;

    out_item_t         token_queue [$];
    out_item_t         staged [MAX_RESULTS];
    int                staged_n;
    out_item_t         oldest;

    function automatic logic is_space(input logic [7:0] b);
        return (b >= CHAR_TAB && b <= CHAR_CR) || b == CHAR_SPACE;
    endfunction

    task automatic clear_line();
        ln_phase  = PH_START;
        cand_mask = '1;
        word_len  = '0;
        cmd_code  = CODE_NONE;
        param_num = '0;
    endtask

    task automatic stage(input logic [1:0] kind, input logic [7:0] idx,
                         input logic [7:0] data, input logic [3:0] code,
                         input logic ok, input logic [7:0] count);
        staged[staged_n] = '{kind, idx, data, code, ok, count, 1'b0};
        staged_n++;
    endtask

    // Narrow the candidate set by one upper-cased letter
    task automatic match_letter(input logic [7:0] b);
        logic [7:0] up;
        up = (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) ? b - CASE_OFFSET : b;
        for (int i = 0; i < NNAMES; i++) begin
            if (word_len >= CMD_LEN[i])
                cand_mask[i] = 1'b0;
            else if (CMD_NAME[i][8*(6-int'(word_len)) +: 8] != up)
                cand_mask[i] = 1'b0;
        end
        if (word_len < LEN_MAX)
            word_len++;
    endtask

    // First surviving name whose length equals the word length
    function automatic logic [3:0] resolve_command();
        for (int i = 0; i < NNAMES; i++) begin
            if (cand_mask[i] && CMD_LEN[i] == int'(word_len))
                return 4'(i + 1);
        end
        return CODE_NONE;
    endfunction

    task automatic close_command();
        cmd_code = resolve_command();
        stage(KIND_COMMAND, 8'd0, 8'd0, cmd_code, 1'b0, 8'd0);
        ln_phase = PH_WAITPARAM;
    endtask

    task automatic close_param();
        stage(KIND_END, param_num, 8'd0, CODE_NONE, 1'b0, 8'd0);
        if (int'(param_num) < MAX_PARAMS)
            param_num++;
    endtask

    // Advance the line state by one byte and queue the tokens it yields
    task automatic predict_byte(input in_item_t req);
        logic [7:0] b;
        logic       sp;
        logic       line_ok;
        int         cnt;
        b  = req.char_byte;
        sp = is_space(b);
        staged_n = 0;
        case (ln_phase)
            PH_START:
                if (!sp) begin
                    if (b == CHAR_COLON)
                        ln_phase = PH_PREFIX;
                    else
                    begin
                        ln_phase = PH_CMD;
                        match_letter(b);
                    end
                end
            PH_PREFIX:
                if (sp)
                    ln_phase = PH_WAITCMD;
            PH_WAITCMD:
                if (!sp) begin
                    ln_phase = PH_CMD;
                    match_letter(b);
                end
            PH_CMD:
                if (sp)
                    close_command();
                else
                    match_letter(b);
            PH_WAITPARAM:
                if (!sp) begin
                    if (b == CHAR_COLON)
                        ln_phase = PH_REST;
                    else
                    begin
                        // second PRIVMSG argument runs to the end of line
                        ln_phase = (cmd_code == CODE_PRIVMSG && param_num == 8'd1)
                                   ? PH_REST : PH_PARAM;
                        stage(KIND_BYTE, param_num, b, CODE_NONE, 1'b0, 8'd0);
                    end
                end
            PH_PARAM:
                if (sp) begin
                    close_param();
                    ln_phase = PH_WAITPARAM;
                end
                else
                    stage(KIND_BYTE, param_num, b, CODE_NONE, 1'b0, 8'd0);
            PH_REST:
                if (b == CHAR_NEWLINE) begin
                    close_param();
                    ln_phase = PH_DONE;
                end
                else
                    stage(KIND_BYTE, param_num, b, CODE_NONE, 1'b0, 8'd0);
            default: ;
        endcase

        // End of line: flush the open word, then the summary
        if (req.end_of_line) begin
            if (ln_phase == PH_CMD)
                close_command();
            else if (ln_phase == PH_PARAM || ln_phase == PH_REST) begin
                close_param();
                ln_phase = PH_DONE;
            end
            line_ok = (ln_phase >= PH_WAITPARAM);
            cnt = 0;
            if (line_ok) begin
                cnt = int'(param_num);
                if (cnt < PAD_PARAMS)
                    cnt = PAD_PARAMS;
                if (cnt > MAX_PARAMS)
                    cnt = MAX_PARAMS;
            end
            stage(KIND_SUMMARY, 8'd0, 8'd0, line_ok ? cmd_code : CODE_NONE, line_ok, 8'(cnt));
            clear_line();
        end

        if (staged_n > 0)
            staged[staged_n-1].last_of_run = 1'b1;
        for (int k = 0; k < staged_n; k++)
            token_queue.insert(token_queue.size(), staged[k]);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Compare the oldest expectation first, then predict the new byte
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_line();
            token_queue.delete();
            tokens_pending = 0;
        end
        else
        begin
            if (tok_valid && !tok_stall) begin
                if (token_queue.size() == 0) begin
                    $error("unexpected token: kind %0d index %0d byte 0x%02h",
                           tok_item.kind, tok_item.param_index, tok_item.data_byte);
                    fail_count++;
                end
                else
                begin
                    oldest = token_queue.pop_front();
                    check_field("kind", 8'(oldest.kind), 8'(tok_item.kind));
                    check_field("param_index", oldest.param_index, tok_item.param_index);
                    check_field("data_byte", oldest.data_byte, tok_item.data_byte);
                    check_field("command_code", 8'(oldest.command_code),
                                8'(tok_item.command_code));
                    check_field("line_valid", 8'(oldest.line_valid), 8'(tok_item.line_valid));
                    check_field("param_count", oldest.param_count, tok_item.param_count);
                    check_field("last_of_run", 8'(oldest.last_of_run),
                                8'(tok_item.last_of_run));
                    tokens_checked++;
                end
            end
            if (char_valid && !char_stall)
                predict_byte(char_item);
            tokens_pending = token_queue.size();
        end
    end

endmodule

// ----- tb/tb_irc_message_tokenizer_top.sv -----
// Testbench top for the IRC message tokenizer: clock, reset, line stimulus and verdict.
// Depends on itk_pkg, irc_message_tokenizer_top and irc_message_tokenizer_checker.
`timescale 1ns / 100ps

module tb_irc_message_tokenizer_top;
    import itk_pkg::*;

    localparam int RANDOM_BYTES  = 140;
    localparam int CROWD_PARAMS  = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS    = 1_000_000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      char_valid = 1'b0;
    in_item_t  char_item = '0;
    logic      char_stall;
    logic      tok_valid;
    logic      tok_stall = 1'b0;
    out_item_t tok_item;

    int        fail_count;
    int        tokens_pending;
    int        tokens_checked;

    int        send_idle_pct = 0;
    int        stall_pct = 0;
    logic      hold_go = 1'b0;
    logic      hold_on = 1'b0;
    int        bytes_sent = 0;
    int        lines_sent = 0;
    int        random_bytes = 0;
    logic [7:0] line_bytes [$];

    irc_message_tokenizer_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_item   (tok_item)
    );

    irc_message_tokenizer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_item      (char_item),
        .tok_valid      (tok_valid),
        .tok_stall      (tok_stall),
        .tok_item       (tok_item),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending),
        .tokens_checked (tokens_checked)
    );

    always #1 clk = ~clk;

    // Token receiver: random stall, forced high during the long hold
    always @(posedge clk)
        tok_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);

    // Long output hold, counted here while the sender keeps pushing
    initial begin : long_hold
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Tab, line feed, vertical tab, form feed, carriage return or space
    function automatic logic [7:0] rand_space();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r);
    endfunction

    // Any byte that neither separates words nor opens a trailing parameter
    function automatic logic [7:0] rand_word_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ((b >= CHAR_TAB && b <= CHAR_CR) || b == CHAR_SPACE || b == CHAR_COLON)
            b = b ^ 8'h40;
        return b;
    endfunction

    // Append one byte to the line being built
    task automatic add_byte(input logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endtask

    // One byte request; valid stays up after acceptance until the next step
    task automatic send_byte(input logic [7:0] b, input logic eol);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= '{char_byte: b, end_of_line: eol};
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !char_stall;
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
        lines_sent++;
    endtask

    task automatic send_text(input string s);
        line_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
        send_line();
    endtask

    // Random line: mostly well formed, some pure noise
    task automatic make_line();
        int          roll;
        int          n;
        int          np;
        int unsigned idx;
        int unsigned nlen;
        logic [7:0]  c;
        line_bytes.delete();
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0: add_byte(rand_space());
                    1: add_byte(CHAR_COLON);
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end

        // optional leading blank and prefix word
        if ($urandom_range(0, 4) == 0)
            add_byte(rand_space());
        if ($urandom_range(0, 3) == 0) begin
            add_byte(CHAR_COLON);
            repeat ($urandom_range(0, 3)) add_byte(rand_word_byte());
            add_byte(rand_space());
        end

        // command word: known name in mixed case, clipped or overlong, or made up
        roll = $urandom_range(0, 9);
        if (roll < 8) begin
            idx  = $urandom_range(0, NNAMES - 1);
            nlen = NAME_LEN[idx];
            if (roll == 7)
                nlen = $urandom_range(1, nlen + 1);
            for (int i = 0; i < nlen; i++) begin
                c = (i < NAME_LEN[idx]) ? NAME_STR[idx][8*(7-i) +: 8] : "X";
                if ($urandom_range(0, 1))
                    c = c | CASE_OFFSET;
                add_byte(c);
            end
        end
        else
        begin
            n = (roll == 8) ? $urandom_range(1, 6) : $urandom_range(14, 17);
            repeat (n) begin
                c = 8'($urandom_range(65, 90));
                if ($urandom_range(0, 1))
                    c = c | CASE_OFFSET;
                add_byte(c);
            end
        end

        // parameters, the last one sometimes a colon trailer
        np = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 3);
        for (int p = 0; p < np; p++) begin
            repeat ($urandom_range(1, 2)) add_byte(rand_space());
            if (p == np - 1 && $urandom_range(0, 2) == 0) begin
                add_byte(CHAR_COLON);
                repeat ($urandom_range(0, 5))
                    add_byte(($urandom_range(0, 3) == 0) ? rand_space()
                             : 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) begin
                    add_byte(CHAR_NEWLINE);
                    repeat ($urandom_range(0, 2))
                        add_byte(8'($urandom_range(0, 255)));
                end
            end
            else
                repeat ($urandom_range(1, 4)) add_byte(rand_word_byte());
        end
        if ($urandom_range(0, 3) == 0)
            add_byte(rand_space());
    endtask

    initial begin : stimulus
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: blank line, prefix only, lone colon with junk after the
        // newline, PRIVMSG trailer holding blanks and a non-ASCII byte
        send_text(" ");
        send_text(":p");
        send_text("KiCk :\nz");
        send_text("privmsg a b \377");

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_go       = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 88;
                    stall_pct     = 0;
                end
                2:
                begin
                    // let everything drain before the next mix
                    char_valid <= 1'b0;
                    @(posedge clk);
                    wait (tokens_pending == 0);
                    @(posedge clk);
                    send_idle_pct = 0;
                    stall_pct     = 88;
                end
                default:
                begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase
            target = (p + 1) * RANDOM_BYTES / 4;
            while (random_bytes < target) begin
                make_line();
                send_line();
                random_bytes += line_bytes.size();
            end
            // one line with more parameters than the padding covers
            if (p == 0) begin
                line_bytes.delete();
                for (int i = 0; i < 4; i++)
                    add_byte(NAME_STR[5][8*(7-i) +: 8]);
                repeat (CROWD_PARAMS) begin
                    add_byte(rand_space());
                    add_byte(rand_word_byte());
                end
                send_line();
            end
        end

        char_valid <= 1'b0;
        @(posedge clk);
        wait (tokens_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d lines, one with %0d parameters, under four idle mixes",
                 bytes_sent, lines_sent, CROWD_PARAMS);
        $display("and a %0d-cycle output hold; %0d tokens compared, %0d failures",
                 HOLD_CYCLES, tokens_checked, fail_count);
        if (fail_count == 0 && tokens_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/itk_pkg.sv
design/itk_core.sv
design/irc_message_tokenizer_top.sv
tb/irc_message_tokenizer_checker.sv
tb/tb_irc_message_tokenizer_top.sv
